// ----- rtl/core/radix_digit_converter_unit_macros.svh -----
// assertion macros for the radix digit converter rtl
// no dependencies; included by modules that carry assertions
`ifndef RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdc assertion failed");

// next-cycle implication
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdc assertion failed");

`else

`define RDC_ASSERT_NOW(label, clk, rst, ante, cons)
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/rdc_pkg.sv -----
// shared types and constants for the radix digit converter
// no dependencies
package rdc_pkg;

  localparam int DATA_W       = 32;
  localparam int CHAR_W       = 8;
  localparam int ALPHA_REGS   = 8;
  localparam int ALPHA_W      = 64;
  localparam int ALPHA_IDX_W  = 6;
  localparam int CFG_IDX_W    = 4;
  localparam int MAX_BASE_DEF = 64;
  localparam int MAX_DIGITS   = 32;
  localparam int DIGIT_CNT_W  = 6;
  localparam int DIV_STEP     = 8;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/core/rdc_channels.sv -----
// valid/ready channel interfaces for the radix digit converter
// depends on rdc_pkg
interface rdc_value_if;
  import rdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface rdc_char_if;
  import rdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ----- rtl/core/rdc_divider.sv -----
// iterative unsigned divider: 32-bit dividend by a small divisor
// several quotient bits per cycle; depends on rdc_pkg
`include "radix_digit_converter_unit_macros.svh"

module rdc_divider #(
  parameter int MAX_BASE = rdc_pkg::MAX_BASE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [rdc_pkg::DATA_W-1:0]           dividend,
  input  logic [$clog2(MAX_BASE+1)-1:0]        divisor,
  output logic                                 done,
  output logic [rdc_pkg::DATA_W-1:0]           quotient,
  output logic [$clog2(MAX_BASE+1)-1:0]        remainder
);
  import rdc_pkg::*;

  localparam int BASE_W = $clog2(MAX_BASE + 1);
  localparam int STEPS  = DATA_W / DIV_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [DATA_W-1:0]   quo;
  logic [BASE_W-1:0]   rem;
  logic [DATA_W-1:0]   quo_next;
  logic [BASE_W-1:0]   rem_next;

  // DIV_STEP restoring steps on a narrow partial remainder
  always_comb begin
    logic [BASE_W:0]   r;
    logic [DATA_W-1:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {r[BASE_W-1:0], q[DATA_W-1]};
      q = {q[DATA_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    quo_next = q;
    rem_next = r[BASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `RDC_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `RDC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `RDC_ASSERT_NEXT(a_last_step_done, clk, rst, busy && !start && step == STEP_W'(STEPS - 1), done)

endmodule

// ----- rtl/core/radix_digit_converter_unit.sv -----
// radix digit converter top level: config registers, alphabet check, digit sequencer
// depends on rdc_pkg, rdc_channels, rdc_divider and the assertion macro header
`include "radix_digit_converter_unit_macros.svh"

// usage:
// - din carries a signed 32-bit value; dout carries one text byte per request,
//   with last set on the final byte of the number
// - cfg_write/cfg_index/cfg_data load the eight 64-bit alphabet registers;
//   writes are expected only while the block is idle
// - per value: accept, scan the alphabet characters (up to MAX_BASE + 1)
//   for the base and validity check, then one division per digit in the
//   shared divider, then emit the characters while dout is ready
// - the shared divider sets the pace: base 2 gives up to 32 digits, so the
//   worst case is a negative value in base 2
// - din.ready is high only when the sequencer is idle; a new value is taken
//   while the final character still waits in the output register
// - an invalid alphabet (base below 2, '+' or '-', a repeated character)
//   drops the value without any output
// - reset clears the alphabet registers and the sequencer; dout holds its
//   character stable while the receiver stalls
module radix_digit_converter_unit #(
  parameter int MAX_BASE = rdc_pkg::MAX_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  rdc_value_if.sink                      din,
  rdc_char_if.source                     dout,
  input  logic                           cfg_write,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdc_pkg::ALPHA_W-1:0]    cfg_data
);
  import rdc_pkg::*;

  localparam int BASE_W = $clog2(MAX_BASE + 1);
  localparam int BUF_W  = $clog2(MAX_DIGITS);

  // configuration
  logic [ALPHA_REGS-1:0][ALPHA_W-1:0] alphabet;

  // sequencer state
  state_t                  state;
  state_t                  state_next;
  logic [BASE_W-1:0]       pos;
  logic [BASE_W-1:0]       base;
  logic [DATA_W-1:0]       mag;
  logic                    sign_pend;
  logic [DIGIT_CNT_W-1:0]  nd;
  logic [DIGIT_CNT_W-1:0]  cnt;
  logic [255:0]            seen;
  logic [CHAR_W-1:0]       digit_buf [MAX_DIGITS];

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  // divider hookup
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [BASE_W-1:0] div_rem;

  // single alphabet read port shared by the scan and digit lookup
  logic [ALPHA_IDX_W-1:0] rd_idx;
  logic [CHAR_W-1:0]      rd_char;

  // decoded conditions
  logic in_fire;
  logic scan_end;
  logic scan_bad;
  logic digit_end;
  logic out_load;

  assign in_fire = din.valid && din.ready;
  assign rd_char = alphabet[rd_idx[ALPHA_IDX_W-1:3]][rd_idx[2:0]*CHAR_W +: CHAR_W];

  assign scan_end  = (pos == BASE_W'(MAX_BASE)) || (rd_char == '0);
  assign scan_bad  = (rd_char == CH_PLUS) || (rd_char == CH_MINUS) || seen[rd_char];
  assign digit_end = (div_quo == '0) || (nd == DIGIT_CNT_W'(MAX_DIGITS - 1));

  // alphabet registers, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= '0;
    end else if (cfg_write && cfg_index < CFG_IDX_W'(ALPHA_REGS)) begin
      alphabet[cfg_index[$clog2(ALPHA_REGS)-1:0]] <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = (pos < BASE_W'(2)) ? S_IDLE : S_DIV;
        end else if (scan_bad) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done && digit_end) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_load && !sign_pend && cnt == DIGIT_CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    din.ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mag;
    rd_idx       = ALPHA_IDX_W'(pos);
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        din.ready = 1'b1;
      end
      S_SCAN: begin
        div_start = scan_end && (pos >= BASE_W'(2));
      end
      S_DIV: begin
        rd_idx       = ALPHA_IDX_W'(div_rem);
        div_start    = div_done && !digit_end;
        div_dividend = div_quo;
      end
      S_EMIT: begin
        out_load = !out_valid || dout.ready;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      base      <= '0;
      nd        <= '0;
      cnt       <= '0;
      sign_pend <= 1'b0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        pos       <= '0;
        nd        <= '0;
        seen      <= '0;
        sign_pend <= din.value[DATA_W-1];
      end
      if (state == S_SCAN) begin
        if (scan_end) begin
          base <= pos;
        end else if (!scan_bad) begin
          seen[rd_char] <= 1'b1;
          pos           <= pos + BASE_W'(1);
        end
      end
      if (state == S_DIV && div_done) begin
        nd <= nd + DIGIT_CNT_W'(1);
        if (digit_end) cnt <= nd + DIGIT_CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else begin
          cnt <= cnt - DIGIT_CNT_W'(1);
        end
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      // two's complement magnitude, unsigned so the most negative value works
      mag <= din.value[DATA_W-1] ? (DATA_W'(0) - DATA_W'(din.value)) : DATA_W'(din.value);
    end else if (state == S_DIV && div_done) begin
      mag <= div_quo;
    end
    if (state == S_DIV && div_done) begin
      digit_buf[nd[BUF_W-1:0]] <= rd_char;
    end
    if (out_load) begin
      if (sign_pend) begin
        out_char <= CH_MINUS;
        out_last <= 1'b0;
      end else begin
        // digits were stored least significant first
        out_char <= digit_buf[BUF_W'(cnt - DIGIT_CNT_W'(1))];
        out_last <= (cnt == DIGIT_CNT_W'(1));
      end
    end
  end

  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.last      = out_last;

  rdc_divider #(
    .MAX_BASE (MAX_BASE)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  `RDC_ASSERT_NEXT(a_accept_scan, clk, rst, in_fire, state == S_SCAN)
  `RDC_ASSERT_NOW(a_div_base_ok, clk, rst, state == S_DIV, base >= BASE_W'(2))
  `RDC_ASSERT_NOW(a_done_in_div, clk, rst, div_done, state == S_DIV && nd < DIGIT_CNT_W'(MAX_DIGITS))
  `RDC_ASSERT_NOW(a_emit_count, clk, rst, state == S_EMIT, cnt != '0)

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// testbench for radix_digit_converter_unit: number to text conversion in a configured base
// depends on rdc_pkg, rdc_channels and the rtl of the unit; predicts every character itself
module tb;
  import rdc_pkg::*;

  // register map of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_FIRST = '0;
  localparam int                   REG_UNMAPPED_FIRST = ALPHA_REGS;
  localparam int                   REG_UNMAPPED_LAST  = (1 << CFG_IDX_W) - 1;

  // positions scanned for the base, as the unit is built with its default
  localparam int SCAN_LIMIT = MAX_BASE_DEF;

  // worst case busy time of one value: accept, scan, divide for 32 digits, emit 33
  // characters; plus some margin
  localparam int DRAIN_CYCLES = 64 + 2 + (SCAN_LIMIT + 1)
                                + (DATA_W / DIV_STEP + 1) * MAX_DIGITS + MAX_DIGITS + 1;
  // cycles with no request on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int MAX_PRINTED = 100;

  // whole alphabet as one vector: character p at bits 8p+7:8p, register k at 64k+63:64k
  typedef logic [ALPHA_REGS*ALPHA_W-1:0] alpha_image_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_final;
  } text_char_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ALPHA_W-1:0]    cfg_data;

  rdc_value_if value_ch ();
  rdc_char_if  text_ch ();

  radix_digit_converter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .din       (value_ch),
    .dout      (text_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the alphabet registers and the characters still to come
  alpha_image_t alphabet_mirror;
  text_char_t   expected_text[$];

  int error_count;
  int quiet_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_request;
  int hold_off_left;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] alphabet_char(input int unsigned pos);
    return alphabet_mirror[CHAR_W * pos +: CHAR_W];
  endfunction

  // base of the mirrored alphabet, zero when the alphabet is unusable
  function automatic int unsigned alphabet_base();
    int unsigned n;
    n = 0;
    // the base ends at the first zero byte, or at the scan limit
    while (n < SCAN_LIMIT && alphabet_char(n) != '0) n++;
    if (n < 2) return 0;
    for (int unsigned i = 0; i < n; i++) begin
      // a sign character cannot be a digit
      if (alphabet_char(i) == CH_PLUS || alphabet_char(i) == CH_MINUS) return 0;
      // every digit must be unique
      for (int unsigned j = i + 1; j < n; j++) begin
        if (alphabet_char(j) == alphabet_char(i)) return 0;
      end
    end
    return n;
  endfunction

  // queue the text of one accepted value
  function automatic void predict_text(input logic signed [DATA_W-1:0] v);
    int unsigned       base;
    logic [DATA_W-1:0] magnitude;
    int unsigned       digit_buf[MAX_DIGITS];
    int                n_digits;
    text_char_t        c;
    base = alphabet_base();
    if (base == 0) return;
    // unsigned magnitude, so the most negative value converts as well
    magnitude = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    n_digits = 0;
    do begin
      digit_buf[n_digits] = magnitude % base;
      n_digits++;
      magnitude = magnitude / base;
    end while (magnitude != 0 && n_digits < MAX_DIGITS);
    if (v[DATA_W-1]) begin
      c.character = CH_MINUS;
      c.is_final  = 1'b0;
      expected_text.push_back(c);
    end
    // most significant digit first, the units digit closes the text
    for (int k = n_digits - 1; k >= 0; k--) begin
      c.character = alphabet_char(digit_buf[k]);
      c.is_final  = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic alpha_image_t pack_alphabet(input string s);
    alpha_image_t img;
    img = '0;
    for (int p = 0; p < s.len(); p++) img[CHAR_W * p +: CHAR_W] = s[p];
    return img;
  endfunction

  // distinct digits without sign characters; junk after the terminator must be ignored
  function automatic alpha_image_t random_alphabet(input int base);
    alpha_image_t      img;
    bit                used[256];
    logic [CHAR_W-1:0] c;
    for (int i = 0; i < 256; i++) used[i] = 1'b0;
    for (int p = 0; p < SCAN_LIMIT; p++)
      img[CHAR_W * p +: CHAR_W] = CHAR_W'($urandom_range(255, 0));
    for (int p = 0; p < base; p++) begin
      do c = CHAR_W'($urandom_range(255, 1)); while (used[c] || c == CH_PLUS || c == CH_MINUS);
      used[c] = 1'b1;
      img[CHAR_W * p +: CHAR_W] = c;
    end
    if (base < SCAN_LIMIT) img[CHAR_W * base +: CHAR_W] = '0;
    return img;
  endfunction

  // break a valid alphabet in one of the ways that silences the unit
  function automatic alpha_image_t corrupt_alphabet(input alpha_image_t img, input int base);
    int src;
    int dst;
    src = $urandom_range(base - 1, 0);
    do dst = $urandom_range(base - 1, 0); while (dst == src);
    case ($urandom_range(3, 0))
      0: begin
        // single digit: base of one
        img = '0;
        img[CHAR_W-1:0] = CHAR_W'($urandom_range(255, 1));
      end
      1: img[CHAR_W * dst +: CHAR_W] = CH_PLUS;
      2: img[CHAR_W * dst +: CHAR_W] = CH_MINUS;
      default: img[CHAR_W * dst +: CHAR_W] = img[CHAR_W * src +: CHAR_W];
    endcase
    return img;
  endfunction

  // values spread over corners, small numbers, powers of the base and random widths
  function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned base);
    logic [DATA_W-1:0] v;
    int                small_val;
    case ($urandom_range(4, 0))
      0: v = $urandom;
      1: begin
        small_val = $urandom_range(200, 0);
        v = small_val - 100;
      end
      2: begin
        case ($urandom_range(3, 0))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      3: begin
        // digit count boundaries: base**k - 1, base**k and base**k + 1
        v = 1;
        repeat ($urandom_range(31, 0)) begin
          if (v <= 32'hFFFF_FFFF / base) v = v * base;
        end
        v = v + $urandom_range(2, 0) - 1;
        if ($urandom_range(1, 0)) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1, 0)) v = -v;
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // channel and port drivers; all entered just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // one request on the value channel; valid stays high for a following request
  task automatic send_value(input logic signed [DATA_W-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < sender_idle_pct) gap++;
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    do @(posedge clk); while (!value_ch.ready);
    predict_text(v);
    @(negedge clk);
  endtask

  // park the sender, let every expected character arrive and the unit run dry
  task automatic wait_until_idle();
    value_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void mirror_config(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [ALPHA_W-1:0] data);
    if (idx < ALPHA_REGS) alphabet_mirror[ALPHA_W * idx +: ALPHA_W] = data;
  endfunction

  // write all alphabet registers, then one unmapped index that must change nothing
  task automatic load_alphabet(input alpha_image_t img);
    logic [CFG_IDX_W-1:0] stray_index;
    logic [ALPHA_W-1:0]   stray_data;
    wait_until_idle();
    for (int k = 0; k < ALPHA_REGS; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_ALPHABET_FIRST + CFG_IDX_W'(k);
      cfg_data  <= img[ALPHA_W * k +: ALPHA_W];
      mirror_config(REG_ALPHABET_FIRST + CFG_IDX_W'(k), img[ALPHA_W * k +: ALPHA_W]);
      @(negedge clk);
    end
    stray_index = CFG_IDX_W'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST));
    stray_data  = {$urandom, $urandom};
    cfg_write <= 1'b1;
    cfg_index <= stray_index;
    cfg_data  <= stray_data;
    mirror_config(stray_index, stray_data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // ready changes on the falling edge; a pending hold-off wins over random stalls
  always @(negedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left    = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_text_char(input logic [CHAR_W-1:0] ch, input logic is_final);
    text_char_t want;
    if (expected_text.size() == 0) begin
      report_mismatch($sformatf("character 0x%02h last %0b with nothing expected", ch, is_final));
      return;
    end
    want = expected_text.pop_front();
    if (ch !== want.character)
      report_mismatch($sformatf("character 0x%02h, expected 0x%02h", ch, want.character));
    if (is_final !== want.is_final)
      report_mismatch($sformatf("last %0b on character 0x%02h, expected %0b",
                                is_final, ch, want.is_final));
  endtask

  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) check_text_char(text_ch.character, text_ch.last);
  end

  // a hung handshake ends the run
  always @(posedge clk) begin
    if (rst || (value_ch.valid && value_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns watchdog: no request for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // cleared alphabet has base zero, so values vanish
  task automatic test_reset_state();
    set_idling(0, 0);
    send_value(32'sd5);
    send_value(-32'sd5);
  endtask

  // decimal digits, with sign bytes and a repeat past the terminator that must not count
  task automatic test_decimal();
    alpha_image_t img;
    img = pack_alphabet("0123456789");
    img[CHAR_W * 11 +: CHAR_W] = CH_PLUS;
    img[CHAR_W * 12 +: CHAR_W] = CH_MINUS;
    img[CHAR_W * 13 +: CHAR_W] = "0";
    load_alphabet(img);
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sd10);
    send_value(-32'sd10);
  endtask

  // smallest base with the extreme byte values as digits: longest texts
  task automatic test_binary();
    alpha_image_t img;
    img = '0;
    img[CHAR_W-1:0]        = 8'h01;
    img[CHAR_W +: CHAR_W]  = 8'hFF;
    load_alphabet(img);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sd0);
  endtask

  // every position filled: base is the scan limit
  task automatic test_full_base();
    alpha_image_t img;
    for (int p = 0; p < SCAN_LIMIT; p++) img[CHAR_W * p +: CHAR_W] = CHAR_W'(8'hC0 + p);
    load_alphabet(img);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sd63);
    send_value(32'sd64);
    send_value(-32'sd64);
  endtask

  // each kind of broken alphabet swallows the value
  task automatic test_invalid_alphabets();
    alpha_image_t img;
    load_alphabet(pack_alphabet("7"));
    send_value(-32'sd3);
    load_alphabet(pack_alphabet("01+3"));
    send_value(32'sd12);
    load_alphabet(pack_alphabet("-123456"));
    send_value(-32'sd12);
    load_alphabet(pack_alphabet("0012"));
    send_value(32'sd2);
    // repeat between the first and the last scanned position
    for (int p = 0; p < SCAN_LIMIT; p++) img[CHAR_W * p +: CHAR_W] = CHAR_W'(8'hC0 + p);
    img[CHAR_W * (SCAN_LIMIT - 1) +: CHAR_W] = 8'hC0;
    load_alphabet(img);
    send_value(32'sh8000_0000);
  endtask

  // output held off for a long time while values keep coming: the unit must stall its input
  task automatic test_output_hold_off();
    set_idling(0, 0);
    load_alphabet(random_alphabet(2));
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (6) send_value(pick_value(2));
  endtask

  // random alphabets and values under every idling mode, then a broken one
  task automatic test_random_conversions();
    alpha_image_t img;
    int           base;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(8, 8);
      endcase
      case (phase)
        0: base = 2;
        1: base = SCAN_LIMIT;
        default: base = $urandom_range(SCAN_LIMIT - 1, 3);
      endcase
      img = random_alphabet(base);
      load_alphabet(img);
      repeat (15) send_value(pick_value(base));
    end
    base = $urandom_range(SCAN_LIMIT, 2);
    load_alphabet(corrupt_alphabet(random_alphabet(base), base));
    repeat (6) send_value(pick_value(base));
  endtask

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    value_ch.valid   = 1'b0;
    value_ch.value   = '0;
    text_ch.ready    = 1'b0;
    alphabet_mirror  = '0;
    error_count      = 0;
    quiet_cycles     = 0;
    hold_off_request = 0;
    hold_off_left    = 0;
    set_idling(0, 0);
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_decimal();
    test_binary();
    test_full_base();
    test_invalid_alphabets();
    test_output_hold_off();
    test_random_conversions();

    // every character in, then a full busy time for anything stray
    wait_until_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rdc_pkg.sv
rtl/core/rdc_channels.sv
rtl/core/rdc_divider.sv
rtl/core/radix_digit_converter_unit.sv
dv/tb.sv
